// File: rtl/core/bfha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfha_pkg
// Shared constants and codes of the best-fit heap allocator.
// ----------------------------------------------------------------------------
package bfha_pkg;
   localparam int MAX_BLOCKS_DEF   = 64;
   localparam int HEADER_BYTES_DEF = 16;
   localparam int MIN_PAYLOAD_DEF  = 16;
   localparam int ALIGN_BYTES_DEF  = 8;
   localparam int ADDR_BITS_DEF    = 24;

   localparam int          FIELD_BITS   = 24;
   localparam int          COUNT_BITS   = 32;
   localparam logic [23:0] HEAP_DEFAULT = 24'd2097152;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO     = 2'd1,
      STATUS_NO_MEM   = 2'd2,
      STATUS_BAD_PTR  = 2'd3
   } status_type;
endpackage
`default_nettype wire

// File: rtl/core/bfha_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfha_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module bfha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/core/best_fit_heap_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_unit
// Best-fit heap allocator with block split and two-sided coalesce.
// ----------------------------------------------------------------------------
// One transaction at a time. The block list lives in a RAM of MAX_BLOCKS
// entries (start, bytes, link) read one entry per step; a walk visits each
// list entry through S_RD and S_CHK (address, then registered read). The
// result waits in an output register, so the next transaction is accepted
// while it waits, but that one does not finish until the register has been
// taken. An allocate walks the whole list once for the best fit and finds
// a spare slot from a flop bitmap with a priority search. A free walks
// until the matching block. Free and in-use flags are flops (set for slot 0
// only, cleared for the rest, on reset and on a write of the heap size
// register), so no clearing pass is needed. Writing the heap size restores
// the single free block and zeroes the statistics.
module best_fit_heap_allocator_unit #(
   parameter int MAX_BLOCKS   = bfha_pkg::MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = bfha_pkg::HEADER_BYTES_DEF,
   parameter int MIN_PAYLOAD  = bfha_pkg::MIN_PAYLOAD_DEF,
   parameter int ALIGN_BYTES  = bfha_pkg::ALIGN_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_opcode,
   input  wire logic [23:0] req_request_bytes,
   input  wire logic [23:0] req_payload_offset,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [1:0]  rsp_status,
   output      logic [23:0] rsp_granted_offset,
   output      logic [23:0] rsp_granted_bytes,
   output      logic [23:0] rsp_allocated_bytes,
   output      logic [31:0] rsp_alloc_total,
   output      logic [31:0] rsp_free_total,
   input  wire logic        csr_wr_en,
   input  wire logic [23:0] csr_wr_data
);
   localparam int SW = $clog2(MAX_BLOCKS);
   localparam int LW = SW + 1;
   localparam int AW = bfha_pkg::ADDR_BITS_DEF;
   localparam int EW = AW + AW + LW;
   localparam logic [LW-1:0] LIST_END = LW'(MAX_BLOCKS);
   localparam logic [AW:0]   HDR      = (AW+1)'(HEADER_BYTES);
   localparam logic [AW:0]   SPLIT_MIN = (AW+1)'(HEADER_BYTES + MIN_PAYLOAD);
   localparam logic [AW-1:0] AMASK_HI = ~AW'(ALIGN_BYTES - 1);
   localparam logic [LW-1:0] STEP_MAX = LW'(MAX_BLOCKS);

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_CHK, S_ALC_RD, S_ALC_W1, S_FREE_N_RD, S_FREE_N,
      S_FREE_P_RD, S_FREE_P, S_DONE
   } state_type;

   // RAM entry: {start, bytes, link}
   logic          we;
   logic [SW-1:0] wa, ra;
   logic [EW-1:0] wd, rdat;

   bfha_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_tab (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rdat)
   );

   wire logic [AW-1:0] r_start = rdat[EW-1 -: AW];
   wire logic [AW-1:0] r_bytes = rdat[LW +: AW];
   wire logic [LW-1:0] r_link  = rdat[LW-1:0];

   state_type        state_ff;
   logic [AW-1:0]    heap_ff;
   logic [MAX_BLOCKS-1:0] free_ff, used_ff;
   logic             init_ff;      // entry 0 of RAM stale until rewritten
   logic [23:0]      inuse_ff;
   logic [31:0]      acnt_ff, fcnt_ff;
   logic             op_ff;
   logic [AW:0]      need_ff;
   logic [AW-1:0]    ptr_ff;
   logic [LW-1:0]    cur_ff, prev_ff, best_ff, steps_ff;
   logic [AW-1:0]    best_bytes_ff, best_start_ff, tmp_bytes_ff, prev_bytes_ff;
   logic [LW-1:0]    best_link_ff;
   logic [AW-1:0]    pstart_ff;
   logic [LW-1:0]    plink_ff;
   logic [1:0]       status_ff;
   logic [23:0]      gofs_ff, gbytes_ff;
   logic             rsp_valid_ff;
   logic [1:0]       rsp_status_ff;
   logic [23:0]      rsp_gofs_ff, rsp_gbytes_ff, rsp_inuse_ff;
   logic [31:0]      rsp_acnt_ff, rsp_fcnt_ff;

   // entry read view, with a fresh entry 0 after reset/config
   logic [AW-1:0] e_start, e_bytes;
   logic [LW-1:0] e_link;
   logic [AW-1:0] heap_pay;
   always_comb begin
      heap_pay = (heap_ff > AW'(HEADER_BYTES)) ? heap_ff - AW'(HEADER_BYTES) : '0;
      if (init_ff && cur_ff == '0) begin
         e_start = '0;
         e_bytes = heap_pay;
         e_link  = LIST_END;
      end else begin
         e_start = r_start;
         e_bytes = r_bytes;
         e_link  = r_link;
      end
   end

   // lowest unused slot
   logic [SW-1:0] spare;
   logic          spare_ok;
   always_comb begin
      spare = '0;
      spare_ok = 1'b0;
      for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            spare = SW'(i);
            spare_ok = 1'b1;
         end
      end
   end

   logic [LW-1:0] nxt;
   assign nxt = (e_link < LIST_END) ? e_link : LIST_END;

   logic [AW:0]   rem;
   logic [AW-1:0] sum_n;
   logic          split_ok;
   assign rem      = {1'b0, best_bytes_ff} - need_ff;
   assign sum_n    = AW'({1'b0, tmp_bytes_ff} + HDR + {1'b0, e_bytes});
   assign split_ok = (rem >= SPLIT_MIN) && spare_ok;

   always_comb begin
      we = 1'b0;
      wa = '0;
      wd = '0;
      ra = cur_ff[SW-1:0];
      if (init_ff) begin
         we = 1'b1;
         wd = {AW'(0), heap_pay, LIST_END};
      end
      if (!init_ff) begin
         case (state_ff)
            S_ALC_RD: begin
               // write back best, trimmed and pointed at the split-off remainder when it splits
               if (best_ff != LIST_END) begin
                  we = 1'b1;
                  wa = best_ff[SW-1:0];
                  if (split_ok) begin
                     wd = {best_start_ff, AW'(need_ff), {1'b0, spare}};
                  end else begin
                     wd = {best_start_ff, best_bytes_ff, best_link_ff};
                  end
               end
            end
            S_ALC_W1: begin
               we = 1'b1;
               wa = spare;
               wd = {AW'({1'b0, best_start_ff} + HDR + need_ff),
                     AW'({1'b0, best_bytes_ff} - need_ff - HDR), best_link_ff};
            end
            S_FREE_N: begin
               if (free_ff[cur_ff[SW-1:0]]) begin
                  we = 1'b1;
                  wa = best_ff[SW-1:0];
                  wd = {best_start_ff, sum_n, e_link};
               end
            end
            S_FREE_P: begin
               we = 1'b1;
               wa = prev_ff[SW-1:0];
               wd = {pstart_ff, prev_bytes_ff, plink_ff};
            end
            default: begin end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         heap_ff      <= AW'(bfha_pkg::HEAP_DEFAULT);
         free_ff      <= MAX_BLOCKS'(1);
         used_ff      <= MAX_BLOCKS'(1);
         init_ff      <= 1'b1;
         inuse_ff     <= '0;
         acnt_ff      <= '0;
         fcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
      end else if (csr_wr_en) begin
         heap_ff  <= csr_wr_data[AW-1:0];
         free_ff  <= MAX_BLOCKS'(1);
         used_ff  <= MAX_BLOCKS'(1);
         init_ff  <= 1'b1;
         inuse_ff <= '0;
         acnt_ff  <= '0;
         fcnt_ff  <= '0;
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end else begin
         init_ff <= 1'b0;
         // post the finished result once the output register is free
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= status_ff;
            rsp_gofs_ff   <= gofs_ff;
            rsp_gbytes_ff <= gbytes_ff;
            rsp_inuse_ff  <= inuse_ff;
            rsp_acnt_ff   <= acnt_ff;
            rsp_fcnt_ff   <= fcnt_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  op_ff    <= req_opcode;
                  need_ff  <= {1'b0, AMASK_HI & AW'({1'b0, req_request_bytes[AW-1:0]}
                                 + (AW+1)'(ALIGN_BYTES - 1))} |
                              ((AW+1)'({1'b0, req_request_bytes[AW-1:0]}
                                 + (AW+1)'(ALIGN_BYTES - 1)) & {1'b1, AW'(0)});
                  ptr_ff   <= req_payload_offset[AW-1:0];
                  cur_ff   <= '0;
                  prev_ff  <= LIST_END;
                  best_ff  <= LIST_END;
                  steps_ff <= '0;
                  gofs_ff  <= '0;
                  gbytes_ff <= '0;
                  if (req_opcode == bfha_pkg::OP_ALLOC && req_request_bytes == '0) begin
                     status_ff <= bfha_pkg::STATUS_ZERO;
                     state_ff  <= S_DONE;
                  end else begin
                     state_ff <= S_RD;
                  end
               end
            end
            S_RD: state_ff <= S_CHK;
            S_CHK: begin
               if (op_ff == bfha_pkg::OP_ALLOC) begin
                  if (free_ff[cur_ff[SW-1:0]] && {1'b0, e_bytes} >= need_ff &&
                      (best_ff == LIST_END || e_bytes < best_bytes_ff)) begin
                     best_ff       <= cur_ff;
                     best_bytes_ff <= e_bytes;
                     best_start_ff <= e_start;
                     best_link_ff  <= e_link;
                  end
                  if (nxt == LIST_END || steps_ff + 1'b1 >= STEP_MAX) begin
                     state_ff <= S_ALC_RD;
                  end else begin
                     cur_ff   <= nxt;
                     steps_ff <= steps_ff + 1'b1;
                     state_ff <= S_RD;
                  end
               end else begin
                  if ({1'b0, e_start} + HDR == {1'b0, ptr_ff}) begin
                     best_ff       <= cur_ff;
                     best_start_ff <= e_start;
                     best_bytes_ff <= e_bytes;
                     tmp_bytes_ff  <= e_bytes;
                     best_link_ff  <= e_link;
                     if (free_ff[cur_ff[SW-1:0]]) begin
                        status_ff <= bfha_pkg::STATUS_BAD_PTR;
                        state_ff  <= S_DONE;
                     end else begin
                        free_ff[cur_ff[SW-1:0]] <= 1'b1;
                        inuse_ff  <= inuse_ff - 24'(e_bytes) - 24'(HEADER_BYTES);
                        fcnt_ff   <= fcnt_ff + 1'b1;
                        status_ff <= bfha_pkg::STATUS_OK;
                        cur_ff    <= (e_link < LIST_END) ? e_link : LIST_END;
                        state_ff  <= (e_link < LIST_END) ? S_FREE_N_RD : S_FREE_P_RD;
                     end
                  end else if (nxt == LIST_END || steps_ff + 1'b1 >= STEP_MAX) begin
                     status_ff <= bfha_pkg::STATUS_BAD_PTR;
                     state_ff  <= S_DONE;
                  end else begin
                     prev_ff       <= cur_ff;
                     prev_bytes_ff <= e_bytes;
                     pstart_ff     <= e_start;
                     cur_ff        <= nxt;
                     steps_ff      <= steps_ff + 1'b1;
                     state_ff      <= S_RD;
                  end
               end
            end
            S_ALC_RD: begin
               // decide split and commit best; writes best entry this cycle
               if (best_ff == LIST_END) begin
                  status_ff <= bfha_pkg::STATUS_NO_MEM;
                  state_ff  <= S_DONE;
               end else begin
                  status_ff <= bfha_pkg::STATUS_OK;
                  free_ff[best_ff[SW-1:0]] <= 1'b0;
                  acnt_ff <= acnt_ff + 1'b1;
                  gofs_ff <= 24'({1'b0, best_start_ff} + HDR);
                  if (split_ok) begin
                     state_ff <= S_ALC_W1;
                     gbytes_ff <= 24'(need_ff);
                     inuse_ff <= inuse_ff + 24'(need_ff) + 24'(HEADER_BYTES);
                  end else begin
                     gbytes_ff <= 24'(best_bytes_ff);
                     inuse_ff <= inuse_ff + 24'(best_bytes_ff) + 24'(HEADER_BYTES);
                     state_ff <= S_DONE;
                  end
               end
            end
            S_ALC_W1: begin
               used_ff[spare] <= 1'b1;
               free_ff[spare] <= 1'b1;
               state_ff       <= S_DONE;
            end
            S_FREE_N_RD: state_ff <= S_FREE_N;
            S_FREE_N: begin
               if (free_ff[cur_ff[SW-1:0]]) begin
                  used_ff[cur_ff[SW-1:0]] <= 1'b0;
                  free_ff[cur_ff[SW-1:0]] <= 1'b0;
                  tmp_bytes_ff <= sum_n;
                  best_link_ff <= e_link;
               end
               state_ff <= S_FREE_P_RD;
            end
            S_FREE_P_RD: begin
               // merge freed block into free predecessor
               if (prev_ff != LIST_END && free_ff[prev_ff[SW-1:0]]) begin
                  prev_bytes_ff <= AW'({1'b0, prev_bytes_ff} + HDR + {1'b0, tmp_bytes_ff});
                  plink_ff      <= best_link_ff;
                  used_ff[best_ff[SW-1:0]] <= 1'b0;
                  free_ff[best_ff[SW-1:0]] <= 1'b0;
                  state_ff <= S_FREE_P;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_FREE_P: state_ff <= S_DONE;
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready           = (state_ff == S_IDLE) && !csr_wr_en;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_offset  = rsp_gofs_ff;
   assign rsp_granted_bytes   = rsp_gbytes_ff;
   assign rsp_allocated_bytes = rsp_inuse_ff;
   assign rsp_alloc_total     = rsp_acnt_ff;
   assign rsp_free_total      = rsp_fcnt_ff;

`ifndef SYNTH
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE)
      else $error("ready outside idle");
   a_slot0_used: assert property (@(posedge clock) disable iff (reset)
      used_ff[0])
      else $error("head slot released");
   a_free_used: assert property (@(posedge clock) disable iff (reset)
      (free_ff & ~used_ff) == '0)
      else $error("free flag on unused slot");
`endif
endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the best-fit heap allocator unit. It keeps its own copy of the
// block table, predicts status, grant and statistics of every request, and
// checks each response in order. Directed requests, a full table, heap size
// extremes and long random alloc/free sequences are run with random gaps on
// the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_top;
   localparam int NBLK  = bfha_pkg::MAX_BLOCKS_DEF;
   localparam int HDR   = bfha_pkg::HEADER_BYTES_DEF;
   localparam int MINP  = bfha_pkg::MIN_PAYLOAD_DEF;
   localparam int ALGN  = bfha_pkg::ALIGN_BYTES_DEF;
   localparam int LEND  = NBLK;
   localparam int SETTLE_CYCLES = 2 * NBLK + 40;

   typedef struct packed {
      bfha_pkg::status_type status;
      logic [23:0] gofs;
      logic [23:0] gbytes;
      logic [23:0] in_use;
      logic [31:0] allocs;
      logic [31:0] frees;
   } grant_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = bfha_pkg::OP_ALLOC;
   logic [23:0] req_request_bytes = '0;
   logic [23:0] req_payload_offset = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [23:0] rsp_granted_offset;
   logic [23:0] rsp_granted_bytes;
   logic [23:0] rsp_allocated_bytes;
   logic [31:0] rsp_alloc_total;
   logic [31:0] rsp_free_total;
   logic        csr_wr_en = 1'b0;
   logic [23:0] csr_wr_data = '0;

   best_fit_heap_allocator_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_request_bytes(req_request_bytes), .req_payload_offset(req_payload_offset),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_granted_offset(rsp_granted_offset), .rsp_granted_bytes(rsp_granted_bytes),
      .rsp_allocated_bytes(rsp_allocated_bytes), .rsp_alloc_total(rsp_alloc_total),
      .rsp_free_total(rsp_free_total),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #10 clock = ~clock;

   // heap table copy
   logic [23:0] blk_start [NBLK];
   logic [23:0] blk_bytes [NBLK];
   logic        blk_free  [NBLK];
   int          blk_link  [NBLK];
   logic        slot_used [NBLK];
   logic [23:0] used_bytes;
   logic [31:0] alloc_cnt;
   logic [31:0] free_cnt;

   grant_type   grant_q[$];
   logic [23:0] live_q[$];
   int          err_count = 0;
   int          burst_left = 0;
   bit          hold_req = 0;
   int          hold_cnt = 0;
   int          stall_mode = 0;

   task automatic rebuild_heap(input logic [23:0] size);
      for (int i = 0; i < NBLK; i++) begin
         blk_start[i] = '0;
         blk_bytes[i] = '0;
         blk_free[i]  = 1'b0;
         blk_link[i]  = 0;
         slot_used[i] = 1'b0;
      end
      blk_bytes[0] = (size > 24'(HDR)) ? size - 24'(HDR) : '0;
      blk_free[0]  = 1'b1;
      blk_link[0]  = LEND;
      slot_used[0] = 1'b1;
      used_bytes = '0;
      alloc_cnt  = '0;
      free_cnt   = '0;
      live_q.delete();
   endtask

   function automatic int next_blk(input int s);
      return (blk_link[s] < NBLK) ? blk_link[s] : LEND;
   endfunction

   task automatic merge_next(input int s, input int n);
      blk_bytes[s] = blk_bytes[s] + 24'(HDR) + blk_bytes[n];
      blk_link[s]  = blk_link[n];
      slot_used[n] = 1'b0;
      blk_free[n]  = 1'b0;
   endtask

   task automatic predict_grant(input logic op, input logic [23:0] rb,
                                input logic [23:0] po);
      grant_type g;
      logic [63:0] need, rem;
      int cur, prev, best, s, n;
      g = '0;
      g.status = bfha_pkg::STATUS_OK;
      if (op == bfha_pkg::OP_ALLOC) begin
         if (rb == 0) begin
            g.status = bfha_pkg::STATUS_ZERO;
         end else begin
            need = (64'(rb) + ALGN - 1) / ALGN * ALGN;
            best = LEND;
            cur = 0;
            for (int k = 0; k < NBLK && cur < NBLK; k++) begin
               if (blk_free[cur] && 64'(blk_bytes[cur]) >= need &&
                   (best == LEND || blk_bytes[cur] < blk_bytes[best]))
                  best = cur;
               cur = next_blk(cur);
            end
            if (best == LEND) begin
               g.status = bfha_pkg::STATUS_NO_MEM;
            end else begin
               rem = 64'(blk_bytes[best]) - need;
               if (rem >= HDR + MINP) begin
                  s = NBLK;
                  for (int i = NBLK - 1; i >= 0; i--)
                     if (!slot_used[i]) s = i;
                  if (s < NBLK) begin
                     slot_used[s] = 1'b1;
                     blk_start[s] = blk_start[best] + 24'(HDR) + need[23:0];
                     blk_bytes[s] = rem[23:0] - 24'(HDR);
                     blk_free[s]  = 1'b1;
                     blk_link[s]  = blk_link[best];
                     blk_link[best] = s;
                     blk_bytes[best] = need[23:0];
                  end
               end
               blk_free[best] = 1'b0;
               used_bytes = used_bytes + blk_bytes[best] + 24'(HDR);
               alloc_cnt++;
               g.gofs   = blk_start[best] + 24'(HDR);
               g.gbytes = blk_bytes[best];
               live_q.push_back(g.gofs);
            end
         end
      end else begin
         prev = LEND;
         cur = 0;
         best = LEND;
         for (int k = 0; k < NBLK && cur < NBLK; k++) begin
            if (32'(blk_start[cur]) + HDR == 32'(po)) begin
               best = cur;
               break;
            end
            prev = cur;
            cur = next_blk(cur);
         end
         if (best == LEND || blk_free[best]) begin
            g.status = bfha_pkg::STATUS_BAD_PTR;
         end else begin
            blk_free[best] = 1'b1;
            used_bytes = used_bytes - blk_bytes[best] - 24'(HDR);
            free_cnt++;
            n = next_blk(best);
            if (n != LEND && blk_free[n]) merge_next(best, n);
            if (prev != LEND && blk_free[prev]) merge_next(prev, best);
            for (int i = 0; i < live_q.size(); i++)
               if (live_q[i] == po) begin
                  live_q.delete(i);
                  break;
               end
         end
      end
      g.in_use = used_bytes;
      g.allocs = alloc_cnt;
      g.frees  = free_cnt;
      grant_q.push_back(g);
   endtask

   // one request transaction, with bursts and gaps on the request side
   task automatic send_req(input logic op, input logic [23:0] rb, input logic [23:0] po);
      if (burst_left == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 0)) @(negedge clock);
         burst_left = $urandom_range(12, 1);
      end else begin
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_opcode         <= op;
      req_request_bytes  <= rb;
      req_payload_offset <= po;
      do @(posedge clock); while (!req_ready);
      predict_grant(op, rb, po);
      burst_left--;
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (grant_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_arena_size(input logic [23:0] size);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      rebuild_heap(size);
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req = 0;
         hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready <= 1'b0;
      end else begin
         if ($urandom_range(63, 0) == 0) stall_mode = $urandom_range(3, 0);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(3, 0) != 0);
            2: rsp_ready <= 1'($urandom_range(1, 0));
            default: rsp_ready <= ($urandom_range(7, 0) == 0);
         endcase
      end
   end

   // response checker
   always @(posedge clock) begin
      grant_type g;
      if (!reset && rsp_valid && rsp_ready) begin
         if (grant_q.size() == 0) begin
            err_count++;
            if (err_count <= 10) $display("unexpected response status %0d", rsp_status);
         end else begin
            g = grant_q.pop_front();
            if (rsp_status !== g.status || rsp_granted_offset !== g.gofs ||
                rsp_granted_bytes !== g.gbytes || rsp_allocated_bytes !== g.in_use ||
                rsp_alloc_total !== g.allocs || rsp_free_total !== g.frees) begin
               err_count++;
               if (err_count <= 10) begin
                  $display("mismatch exp st=%0d ofs=%h by=%h use=%h a=%0d f=%0d",
                     g.status, g.gofs, g.gbytes, g.in_use, g.allocs, g.frees);
                  $display("         got st=%0d ofs=%h by=%h use=%h a=%0d f=%0d",
                     rsp_status, rsp_granted_offset, rsp_granted_bytes,
                     rsp_allocated_bytes, rsp_alloc_total, rsp_free_total);
               end
            end
         end
      end
   end

   task automatic test_directed;
      send_req(bfha_pkg::OP_ALLOC, 24'd0, 24'hFFFFFF);
      send_req(bfha_pkg::OP_ALLOC, 24'd1, 24'd0);
      send_req(bfha_pkg::OP_ALLOC, 24'hFFFFFF, 24'd0);
      send_req(bfha_pkg::OP_ALLOC, 24'd24, 24'd0);
      send_req(bfha_pkg::OP_ALLOC, 24'd2097136, 24'd0);
      send_req(bfha_pkg::OP_FREE, 24'hFFFFFF, 24'd0);
      send_req(bfha_pkg::OP_FREE, 24'd0, 24'hFFFFFF);
      send_req(bfha_pkg::OP_FREE, 24'd0, 24'd16);
      send_req(bfha_pkg::OP_FREE, 24'd0, 24'd16);
      send_req(bfha_pkg::OP_FREE, 24'd0, 24'd17);
      send_req(bfha_pkg::OP_ALLOC, 24'd8, 24'd0);
      send_req(bfha_pkg::OP_ALLOC, 24'd9, 24'd0);
      send_req(bfha_pkg::OP_FREE, 24'd0, 24'd40);
      send_req(bfha_pkg::OP_FREE, 24'd0, 24'd16);
      write_arena_size(24'd64);
      send_req(bfha_pkg::OP_ALLOC, 24'd48, 24'd0);
      send_req(bfha_pkg::OP_ALLOC, 24'd49, 24'd0);
      send_req(bfha_pkg::OP_ALLOC, 24'd16, 24'd0);
      send_req(bfha_pkg::OP_ALLOC, 24'd8, 24'd0);
      write_arena_size(24'd8);
      send_req(bfha_pkg::OP_ALLOC, 24'd1, 24'd0);
      send_req(bfha_pkg::OP_FREE, 24'd0, 24'd16);
      write_arena_size(24'd0);
      send_req(bfha_pkg::OP_ALLOC, 24'd1, 24'd0);
      write_arena_size(24'hFFFFFF);
      send_req(bfha_pkg::OP_ALLOC, 24'hFFFFEF, 24'd0);
      send_req(bfha_pkg::OP_FREE, 24'd0, 24'd16);
   endtask

   task automatic test_table_full;
      write_arena_size(24'd4096);
      for (int i = 0; i < NBLK + 4; i++) send_req(bfha_pkg::OP_ALLOC, 24'd8, 24'd0);
      // free every other block, then the rest, to merge both sides
      for (int i = 0; i < NBLK + 4; i += 2)
         send_req(bfha_pkg::OP_FREE, 24'd0, 24'(16 + 24 * i));
      for (int i = 1; i < NBLK + 4; i += 2)
         send_req(bfha_pkg::OP_FREE, 24'd0, 24'(16 + 24 * i));
      drain();
   endtask

   task automatic test_backpressure;
      write_arena_size(24'd8192);
      hold_req = 1;
      for (int i = 0; i < 12; i++)
         send_req(bfha_pkg::OP_ALLOC, 24'($urandom_range(64, 1)), 24'd0);
      drain();
   endtask

   task automatic random_phase(input logic [23:0] size, input int count);
      logic [23:0] rb, po;
      int pick, idx;
      write_arena_size(size);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99, 0);
         rb = 24'($urandom());
         po = 24'($urandom());
         if (pick < 45 && live_q.size() != 0) begin
            idx = $urandom_range(live_q.size() - 1, 0);
            send_req(bfha_pkg::OP_FREE, rb, live_q[idx]);
         end else if (pick < 53) begin
            if (pick < 50 && live_q.size() != 0 && pick[0])
               po = live_q[$urandom_range(live_q.size() - 1, 0)] + 24'($urandom_range(7, 1));
            send_req(bfha_pkg::OP_FREE, rb, po);
         end else begin
            case ($urandom_range(19, 0))
               0: rb = 24'($urandom());
               1: rb = 24'($urandom_range(32'(size), 0));
               2, 3, 4: rb = 24'($urandom_range(512, 0));
               default: rb = 24'($urandom_range(96, 1));
            endcase
            send_req(bfha_pkg::OP_ALLOC, rb, po);
         end
      end
      drain();
   endtask

   task automatic test_random;
      random_phase(24'd2048, 400);
      random_phase(24'd64, 100);
      random_phase(24'($urandom_range(20000, 200)), 350);
      random_phase(24'd700, 250);
      random_phase(24'hFFFFFF, 250);
      random_phase(24'd4096, 230);
   endtask

   initial begin
      rebuild_heap(bfha_pkg::HEAP_DEFAULT);
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_table_full();
      test_backpressure();
      test_random();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (err_count == 0 && grant_q.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("tb_top: done, errors");
      $finish;
   end
endmodule

// File: filelist.f
rtl/core/bfha_pkg.sv
rtl/core/bfha_ram.sv
rtl/core/best_fit_heap_allocator_unit.sv
tb/tb_top.sv
